// File: rtl/binary_to_decimal_ascii_digits_unit_macros.svh
// assertion macros for the binary to decimal ascii digit unit
// uses the clk_i and rst_ni names of the module that includes it
`ifndef BINARY_TO_DECIMAL_ASCII_DIGITS_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_DIGITS_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define B2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define B2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/b2d_pkg.sv
// shared constants and helpers for the binary to decimal ascii digit unit
// no dependencies
`default_nettype none

package b2d_pkg;

  // default width of the binary input
  localparam int unsigned DefInputWidth = 32;

  // shift-add-3 steps done in one pipeline stage
  localparam int unsigned BitsPerStage = 8;

  // one bcd digit
  localparam int unsigned DigitW = 4;

  localparam logic [DigitW-1:0] AdjustLimit = 4'd5;
  localparam logic [DigitW-1:0] AdjustAdd   = 4'd3;

  // ascii '0'
  localparam logic [5:0] AsciiZero = 6'(3 << 4);

  // decimal digits needed for an all-ones word of the given width
  // 1233/4096 is just below log10(2), exact for widths up to 64
  function automatic int unsigned num_digits(input int unsigned width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b2d_dabble_stage.sv
// one pipeline stage of the shift-add-3 converter: a fixed number of bit steps
// then a register with valid/ready; depends on b2d_pkg
`default_nettype none

module b2d_dabble_stage import b2d_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 10,
  parameter int unsigned BIN_W      = 32,
  parameter int unsigned STEPS      = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [NUM_DIGITS*DigitW-1:0] bcd_i,
  input  wire logic [BIN_W-1:0]             bin_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output logic      [NUM_DIGITS*DigitW-1:0] bcd_o,
  output logic      [BIN_W-1:0]             bin_o
);

  localparam int unsigned BcdW = NUM_DIGITS * DigitW;

  logic            valid_q;
  logic [BcdW-1:0] bcd_d, bcd_q;
  logic [BIN_W-1:0] bin_d, bin_q;

  // adjust digits of five or more, then shift in the next binary bit
  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_d[d*DigitW +: DigitW] >= AdjustLimit) begin
          bcd_d[d*DigitW +: DigitW] = bcd_d[d*DigitW +: DigitW] + AdjustAdd;
        end
      end
      bcd_d = {bcd_d[BcdW-2:0], bin_d[BIN_W-1]};
      bin_d = {bin_d[BIN_W-2:0], 1'b0};
    end
  end

  // stage holds while the next one is full and stalled
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

`default_nettype wire

// File: rtl/b2d_serializer.sv
// digit emitter: takes a finished bcd word and sends its digits one per
// request, most significant nonzero first; depends on b2d_pkg
`default_nettype none

module b2d_serializer import b2d_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [NUM_DIGITS*DigitW-1:0] bcd_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output logic      [5:0]                   digit_char_o,
  output logic                              is_last_o
);

  localparam int unsigned CntW = $clog2(NUM_DIGITS);

  logic                valid_q;
  logic [CntW-1:0]     cnt_d, cnt_q;
  logic [DigitW-1:0]   digits_q [NUM_DIGITS];
  logic [CntW-1:0]     lead;
  logic                last;
  logic                load;

  // position of the leading nonzero digit, zero gives the units digit
  always_comb begin
    lead = '0;
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (bcd_i[d*DigitW +: DigitW] != '0) begin
        lead = CntW'(d);
      end
    end
  end

  assign last    = (cnt_q == '0);
  assign ready_o = !valid_q || (ready_i && last);
  assign load    = valid_i && ready_o;

  // digit pointer counts down toward the units digit
  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = lead;
    end else if (valid_q && ready_i && !last) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (ready_i && last) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        digits_q[d] <= bcd_i[d*DigitW +: DigitW];
      end
    end
  end

  assign valid_o      = valid_q;
  assign digit_char_o = AsciiZero | {2'b00, digits_q[cnt_q]};
  assign is_last_o    = last;

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii_digits_unit.sv
// Converts an unsigned INPUT_WIDTH-bit number to its decimal ASCII digits,
// most significant first, no leading zeros (zero gives a single '0'), with
// is_last on the units digit. The shift-add-3 conversion runs in
// ceil(INPUT_WIDTH/8) pipeline stages of eight bit steps each (four at the
// default width), followed by a digit emitter. The emitter sends one digit
// per cycle while out_ready_i is high, so an item holds it for as many
// steps as it has digits (1 to 10 at the default width); the digit count
// sets the sustained rate, and the conversion stages fill behind it so the
// next item is ready at once.
// Depends on b2d_pkg, b2d_dabble_stage, b2d_serializer and the macro header.
`default_nettype none

`include "binary_to_decimal_ascii_digits_unit_macros.svh"

module binary_to_decimal_ascii_digits_unit import b2d_pkg::*; #(
  parameter int unsigned INPUT_WIDTH = DefInputWidth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [INPUT_WIDTH-1:0] value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [5:0]             digit_char_o,
  output logic                        is_last_o
);

  localparam int unsigned NumDigits = num_digits(INPUT_WIDTH);
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned NumStages = (INPUT_WIDTH + BitsPerStage - 1) / BitsPerStage;
  localparam int unsigned BinW      = NumStages * BitsPerStage;

  logic            stg_valid [NumStages+1];
  logic            stg_ready [NumStages+1];
  logic [BcdW-1:0] stg_bcd   [NumStages+1];
  logic [BinW-1:0] stg_bin   [NumStages+1];

  // pipeline entry: empty bcd word, input zero-extended to whole stages
  assign stg_valid[0] = in_valid_i;
  assign in_ready_o   = stg_ready[0];
  assign stg_bcd[0]   = '0;
  assign stg_bin[0]   = BinW'(value_i);

  // conversion stages
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    b2d_dabble_stage #(
      .NUM_DIGITS (NumDigits),
      .BIN_W      (BinW),
      .STEPS      (BitsPerStage)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .bcd_i   (stg_bcd[k]),
      .bin_i   (stg_bin[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .bcd_o   (stg_bcd[k+1]),
      .bin_o   (stg_bin[k+1])
    );
  end

  // digit emitter
  b2d_serializer #(
    .NUM_DIGITS (NumDigits)
  ) u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (stg_valid[NumStages]),
    .ready_o      (stg_ready[NumStages]),
    .bcd_i        (stg_bcd[NumStages]),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .digit_char_o (digit_char_o),
    .is_last_o    (is_last_o)
  );

  // checks on the conversion and the digit run
  `B2D_ASSERT_NOW(a_digit_is_decimal, out_valid_o,
    digit_char_o[5:4] == 2'b11 && digit_char_o[3:0] <= 4'd9, "digit outside 0..9")
  `B2D_ASSERT_NEXT(a_load_shows_digit, stg_valid[NumStages] && stg_ready[NumStages],
    out_valid_o, "loaded word produced no digit")
  `B2D_ASSERT_NEXT(a_run_continues, out_valid_o && out_ready_i && !is_last_o,
    out_valid_o, "digit run broke before the last digit")

endmodule

`default_nettype wire
